// File: hdl/xld_pkg.sv
package xld_pkg;

  // Longest legal instruction; a longer one is cut off on this byte
  localparam int unsigned MAX_INSTR_BYTES = 15;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned SPAN_W          = 6;
  localparam int unsigned MIN_W           = 5;

  // Default depth of the queue between the decoder and the span stage
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Register indexes; register i sits at byte address 4*i
  localparam logic REG_MIN_SPAN = 1'b0;
  localparam logic REG_MAX_SPAN = 1'b1;

  // Reset values of the configuration registers
  localparam logic [MIN_W-1:0]  MIN_SPAN_RESET = 5'd14;
  localparam logic [SPAN_W-1:0] MAX_SPAN_RESET = 6'd30;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       new_span;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  instr_length;
    logic [SPAN_W-1:0] span_length;
    logic              span_done;
    logic              span_error;
    logic              too_long;
  } out_item_t;

  // One decoded instruction on its way to the span stage
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             too_long;
    logic             span_clear;
  } entry_t;

  // Span limits from the register file
  typedef struct packed {
    logic [MIN_W-1:0]  min_span;
    logic [SPAN_W-1:0] max_span;
  } span_cfg_t;

endpackage

// File: hdl/xld_front.sv
module xld_front
  import xld_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     push_o,
  output entry_t   entry_o
);

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_ESC,
    PH_ESC3,
    PH_MODRM,
    PH_SIB,
    PH_TAIL
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             opsize_q, opsize_d;
  logic             rexw_q, rexw_d;
  logic [7:0]       opc_q, opc_d;
  logic [3:0]       imm_q, imm_d;
  logic [3:0]       rem_q, rem_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             clr_q, clr_d;

  logic             done;
  logic             cut;
  logic             tail_go;
  logic [3:0]       tail_n;
  logic [3:0]       word;
  logic [3:0]       disp;
  logic [1:0]       mod_f;
  logic [2:0]       reg_f;
  logic [2:0]       rm_f;
  logic [7:0]       b;
  logic             clr_any;

  // Byte decode: one step of the instruction parser per accepted byte
  always_comb begin
    phase_d  = phase_q;
    opsize_d = opsize_q;
    rexw_d   = rexw_q;
    opc_d    = opc_q;
    imm_d    = imm_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    done     = 1'b0;
    tail_go  = 1'b0;
    tail_n   = '0;
    disp     = '0;
    b        = item_i.code_byte;
    mod_f    = b[7:6];
    reg_f    = b[5:3];
    rm_f     = b[2:0];

    // new span drops any partial instruction
    if (item_i.new_span) begin
      phase_d  = PH_PREFIX;
      opsize_d = 1'b0;
      rexw_d   = 1'b0;
      opc_d    = '0;
      imm_d    = '0;
      rem_d    = '0;
      cnt_d    = '0;
    end
    cnt_d = cnt_d + 1'b1;
    word  = opsize_d ? 4'd2 : 4'd4;

    unique case (phase_d)
      PH_ESC: begin
        priority if (b == 8'h38) begin
          imm_d   = 4'd0;
          phase_d = PH_ESC3;
        end else if (b == 8'h3A) begin
          imm_d   = 4'd1;
          phase_d = PH_ESC3;
        end else if (b >= 8'h80 && b <= 8'h8F) begin
          tail_go = 1'b1;
          tail_n  = 4'd4;
        end else if (b == 8'h05) begin
          done = 1'b1;
        end else begin
          opc_d   = 8'h0F;
          imm_d   = 4'd0;
          phase_d = PH_MODRM;
        end
      end
      PH_ESC3: begin
        opc_d   = 8'h0F;
        phase_d = PH_MODRM;
      end
      PH_MODRM: begin
        // F6 / F7 carry an immediate only for the TEST forms
        if (opc_d == 8'hF6) imm_d = (reg_f <= 3'd1) ? 4'd1 : 4'd0;
        if (opc_d == 8'hF7) imm_d = (reg_f <= 3'd1) ? word : 4'd0;
        priority if (mod_f == 2'd0 && rm_f == 3'd5) disp = 4'd4;
        else if (mod_f == 2'd1) disp = 4'd1;
        else if (mod_f == 2'd2) disp = 4'd4;
        else disp = 4'd0;
        if (mod_f != 2'd3 && rm_f == 3'd4) begin
          rem_d   = disp;
          phase_d = PH_SIB;
        end else begin
          tail_go = 1'b1;
          tail_n  = disp + imm_d;
        end
      end
      PH_SIB: begin
        // no base under mod 0 means a 32-bit displacement follows
        disp = rem_d;
        if (disp == 4'd0 && b[2:0] == 3'd5) disp = 4'd4;
        tail_go = 1'b1;
        tail_n  = disp + imm_d;
      end
      PH_TAIL: begin
        rem_d = rem_d - 1'b1;
        done  = (rem_d == 4'd0);
      end
      default: begin
        phase_d = PH_PREFIX;
        priority if (b == 8'h66) begin
          opsize_d = 1'b1;
        end else if (b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
                     b == 8'h2E || b == 8'h3E || b == 8'h26 || b == 8'h36 ||
                     b == 8'h64 || b == 8'h65) begin
          // skipped legacy prefix
        end else if (b >= 8'h40 && b <= 8'h4F) begin
          rexw_d = b[3];
        end else if (b == 8'h0F) begin
          opc_d   = b;
          phase_d = PH_ESC;
        end else if (b == 8'h90 || b == 8'hCC || b == 8'hC3) begin
          done = 1'b1;
        end else if (b == 8'hC2) begin
          tail_go = 1'b1;
          tail_n  = 4'd2;
        end else if (b >= 8'h50 && b <= 8'h5F) begin
          done = 1'b1;
        end else if (b >= 8'hB8 && b <= 8'hBF) begin
          tail_go = 1'b1;
          tail_n  = rexw_d ? 4'd8 : 4'd4;
        end else if ((b >= 8'hB0 && b <= 8'hB7) || b == 8'hEB ||
                     (b >= 8'h70 && b <= 8'h7F)) begin
          tail_go = 1'b1;
          tail_n  = 4'd1;
        end else if (b == 8'hE9 || b == 8'hE8) begin
          tail_go = 1'b1;
          tail_n  = 4'd4;
        end else if ((b >= 8'h91 && b <= 8'h97) || (b >= 8'hFA && b <= 8'hFD) ||
                     b == 8'hC9 || b == 8'h98 || b == 8'h99) begin
          done = 1'b1;
        end else if ((b & 8'hC4) == 8'h00) begin
          opc_d   = b;
          imm_d   = 4'd0;
          phase_d = PH_MODRM;
        end else if ((b & 8'h06) == 8'h04 && b < 8'h40) begin
          // ALU op with accumulator and immediate
          tail_go = 1'b1;
          tail_n  = b[0] ? word : 4'd1;
        end else if (b == 8'h80 || b == 8'h83) begin
          opc_d   = b;
          imm_d   = 4'd1;
          phase_d = PH_MODRM;
        end else if (b == 8'h81) begin
          opc_d   = b;
          imm_d   = word;
          phase_d = PH_MODRM;
        end else if (b >= 8'h84 && b <= 8'h8E) begin
          opc_d   = b;
          imm_d   = 4'd0;
          phase_d = PH_MODRM;
        end else if (b == 8'hA8) begin
          tail_go = 1'b1;
          tail_n  = 4'd1;
        end else if (b == 8'hA9) begin
          tail_go = 1'b1;
          tail_n  = word;
        end else if (b == 8'hC6 || b == 8'hC0 || b == 8'hC1) begin
          opc_d   = b;
          imm_d   = 4'd1;
          phase_d = PH_MODRM;
        end else if (b == 8'hC7) begin
          opc_d   = b;
          imm_d   = word;
          phase_d = PH_MODRM;
        end else if (b >= 8'hD0 && b <= 8'hD3) begin
          opc_d   = b;
          imm_d   = 4'd0;
          phase_d = PH_MODRM;
        end else if (b == 8'h6A) begin
          tail_go = 1'b1;
          tail_n  = 4'd1;
        end else if (b == 8'h68) begin
          tail_go = 1'b1;
          tail_n  = 4'd4;
        end else if (b == 8'h6B) begin
          opc_d   = b;
          imm_d   = 4'd1;
          phase_d = PH_MODRM;
        end else if (b == 8'h69) begin
          opc_d   = b;
          imm_d   = word;
          phase_d = PH_MODRM;
        end else if (b == 8'hFE || b == 8'hFF || b == 8'hF6 || b == 8'hF7) begin
          opc_d   = b;
          imm_d   = 4'd0;
          phase_d = PH_MODRM;
        end else if (b >= 8'hA4 && b <= 8'hAF) begin
          done = 1'b1;
        end else if (b >= 8'hE0 && b <= 8'hE7) begin
          tail_go = 1'b1;
          tail_n  = 4'd1;
        end else begin
          // unlisted opcode: one byte
          done = 1'b1;
        end
      end
    endcase

    // displacement and immediate bytes still to come
    if (tail_go) begin
      if (tail_n == 4'd0) begin
        done = 1'b1;
      end else begin
        rem_d   = tail_n;
        phase_d = PH_TAIL;
      end
    end
  end

  assign cut     = !done && (cnt_d >= LEN_W'(MAX_INSTR_BYTES));
  assign push_o  = accept_i && (done || cut);
  assign clr_any = clr_q || item_i.new_span;
  assign clr_d   = push_o ? 1'b0 : (accept_i ? clr_any : clr_q);

  assign entry_o.len        = cnt_d;
  assign entry_o.too_long   = cut;
  assign entry_o.span_clear = clr_any;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX;
      opsize_q <= 1'b0;
      rexw_q   <= 1'b0;
      opc_q    <= '0;
      imm_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      clr_q    <= 1'b0;
    end else begin
      clr_q <= clr_d;
      if (push_o) begin
        phase_q  <= PH_PREFIX;
        opsize_q <= 1'b0;
        rexw_q   <= 1'b0;
        opc_q    <= '0;
        imm_q    <= '0;
        rem_q    <= '0;
        cnt_q    <= '0;
      end else if (accept_i) begin
        phase_q  <= phase_d;
        opsize_q <= opsize_d;
        rexw_q   <= rexw_d;
        opc_q    <= opc_d;
        imm_q    <= imm_d;
        rem_q    <= rem_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  a_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> entry_o.len != '0)
    else $error("instruction of zero length emitted");

  a_cut_at_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.too_long) |-> entry_o.len == LEN_W'(MAX_INSTR_BYTES))
    else $error("overlong instruction not cut at the byte limit");

endmodule

// File: hdl/xld_queue.sv
module xld_queue
  import xld_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// File: hdl/xld_back.sv
module xld_back
  import xld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  span_cfg_t cfg_i,
  input  logic      q_valid_i,
  input  entry_t    q_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [SPAN_W-1:0] total_q;
  logic [SPAN_W-1:0] base;
  logic [SPAN_W:0]   sum;
  logic [SPAN_W-1:0] span;
  logic              valid_q;
  out_item_t         data_q;

  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  // Span accumulate with saturation
  always_comb begin
    base = q_data_i.span_clear ? '0 : total_q;
    sum  = {1'b0, base} + (SPAN_W + 1)'(q_data_i.len);
    span = sum[SPAN_W] ? '1 : sum[SPAN_W-1:0];
  end

  // Span total and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        total_q <= span;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q.instr_length <= q_data_i.len;
      data_q.span_length  <= span;
      data_q.span_done    <= (span >= SPAN_W'(cfg_i.min_span));
      data_q.span_error   <= (span > cfg_i.max_span);
      data_q.too_long     <= q_data_i.too_long;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hdl/x86_64_instruction_length_decoder.sv
// x86-64 instruction length decoder. Code bytes enter one per transaction on
// the input channel, and the block takes one byte every cycle while the queue
// has room; throughput is set by the single-byte parser step in the front
// decoder. Each instruction yields one result transaction, written by the
// decoder into the queue and then by the span stage into the output register,
// with its length, the running span total saturating at 63, the span_done /
// span_error flags against min_span and max_span, and too_long when the
// instruction was cut off at 15 bytes. A queue of QUEUE_DEPTH entries plus
// the output register absorb output stalls; input is refused only once both
// are full. new_span drops any partial instruction and restarts the span.
// Registers: min_span at address 0, max_span at address 4 (APB, no waits).
module x86_64_instruction_length_decoder
  import xld_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  span_cfg_t cfg_q;
  logic      accept;
  logic      push;
  entry_t    push_data;
  logic      q_full;
  logic      q_valid;
  entry_t    q_data;
  logic      pop;
  logic      wr_en;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_span <= MIN_SPAN_RESET;
      cfg_q.max_span <= MAX_SPAN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MIN_SPAN: cfg_q.min_span <= pwdata[MIN_W-1:0];
        REG_MAX_SPAN: cfg_q.max_span <= pwdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_SPAN: prdata = 32'(cfg_q.min_span);
      REG_MAX_SPAN: prdata = 32'(cfg_q.max_span);
      default:      prdata = '0;
    endcase
  end

  // Front: byte parser
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  xld_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push),
    .entry_o  (push_data)
  );

  // Decoupling queue
  xld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // Back: span accounting and result register
  xld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule
